@@ rtl/swap_permutation_enumerator_core_macros.svh @@
// assertion macros for the swap permutation enumerator
`ifndef SWAP_PERMUTATION_ENUMERATOR_CORE_MACROS_SVH
`define SWAP_PERMUTATION_ENUMERATOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPE_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spe_pkg.sv @@
// shared constants and types of the swap permutation enumerator
package spe_pkg;

  localparam int MAX_ELEMENTS = 8;
  localparam int IDX_W        = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int N_W          = $clog2(MAX_ELEMENTS + 1);
  localparam int DATA_DEPTH   = 2 * MAX_ELEMENTS;
  localparam int DADDR_W      = IDX_W + 1;

  localparam int COUNT_W = 4;
  localparam int POS_W   = 3;
  localparam int VALUE_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_ADVANCE = 1'b1;

  typedef struct packed {
    logic                      valid;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      last;
    logic                      exhausted;
  } emit_t;

endpackage

@@ rtl/spe_ram.sv @@
// generic single-write, single-read synchronous ram with registered read
module spe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/spe_seq.sv @@
// sequencer: element/work ram, choice stack ram, backtracking walk and emission
module spe_seq (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_fire,
  input  logic                               in_opcode,
  input  logic [spe_pkg::POS_W-1:0]          in_position,
  input  logic signed [spe_pkg::VALUE_W-1:0] in_element_value,
  input  logic                               cfg_we,
  input  logic [spe_pkg::N_W-1:0]            n,
  input  logic                               out_free,
  output logic                               busy,
  output spe_pkg::emit_t                     emit
);
  import spe_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WALK = 3'd1;
  localparam logic [2:0] S_E0   = 3'd2;
  localparam logic [2:0] S_E1   = 3'd3;
  localparam logic [2:0] S_E2   = 3'd4;
  localparam logic [2:0] S_EXH  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic                    started_r, started_nxt;
  logic                    done_r, done_nxt;
  logic [MAX_ELEMENTS-1:0] cvalid_r, cvalid_nxt;
  logic [MAX_ELEMENTS-1:0] wvalid_r, wvalid_nxt;
  logic [IDX_W-1:0]        lvl_r, lvl_nxt;
  logic [IDX_W-1:0]        k_r, k_nxt;
  logic [IDX_W-1:0]        c_r, c_nxt;
  logic [VALUE_W-1:0]      workk_r, workk_nxt;

  logic                    dwe, dre;
  logic [DADDR_W-1:0]      dwaddr, draddr;
  logic [VALUE_W-1:0]      dwdata, drdata;
  logic                    cwe, cre;
  logic [IDX_W-1:0]        cwaddr, craddr, cwdata, crdata;

  logic [IDX_W-1:0]        walk_val, emit_val, emit_c;
  logic                    last_k;

  spe_ram #(.WIDTH(VALUE_W), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (dwe),
    .waddr (dwaddr),
    .wdata (dwdata),
    .re    (dre),
    .raddr (draddr),
    .rdata (drdata)
  );

  spe_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_choice_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (cwaddr),
    .wdata (cwdata),
    .re    (cre),
    .raddr (craddr),
    .rdata (crdata)
  );

  // unwritten choice entries read as identity
  assign walk_val = cvalid_r[lvl_r] ? crdata : lvl_r;
  assign emit_val = cvalid_r[k_r] ? crdata : k_r;
  assign last_k   = (N_W'(k_r) == (n - N_W'(1)));
  assign emit_c   = (last_k || (N_W'(emit_val) >= n)) ? k_r : emit_val;
  assign busy     = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    started_nxt = started_r;
    done_nxt    = done_r;
    cvalid_nxt  = cvalid_r;
    wvalid_nxt  = wvalid_r;
    lvl_nxt     = lvl_r;
    k_nxt       = k_r;
    c_nxt       = c_r;
    workk_nxt   = workk_r;
    dwe         = 1'b0;
    dwaddr      = '0;
    dwdata      = '0;
    dre         = 1'b0;
    draddr      = '0;
    cwe         = 1'b0;
    cwaddr      = '0;
    cwdata      = '0;
    cre         = 1'b0;
    craddr      = '0;
    emit        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          started_nxt = 1'b0;
          done_nxt    = 1'b0;
        end
        if (in_fire) begin
          if (in_opcode == OP_LOAD) begin
            if (int'(in_position) < MAX_ELEMENTS) begin
              dwe    = 1'b1;
              dwaddr = {1'b0, IDX_W'(in_position)};
              dwdata = in_element_value;
            end
            started_nxt = 1'b0;
            done_nxt    = 1'b0;
          end else if (done_r) begin
            state_nxt = S_EXH;
          end else if (!started_r) begin
            started_nxt = 1'b1;
            cvalid_nxt  = '0;
            wvalid_nxt  = '0;
            k_nxt       = '0;
            state_nxt   = S_E0;
          end else if (n == N_W'(1)) begin
            done_nxt  = 1'b1;
            state_nxt = S_EXH;
          end else begin
            lvl_nxt   = IDX_W'(n - N_W'(2));
            cre       = 1'b1;
            craddr    = IDX_W'(n - N_W'(2));
            state_nxt = S_WALK;
          end
        end
      end
      S_WALK: begin
        if ((N_W'(walk_val) + N_W'(1)) < n) begin
          cwe    = 1'b1;
          cwaddr = lvl_r;
          cwdata = IDX_W'(N_W'(walk_val) + N_W'(1));
          for (int j = 0; j < MAX_ELEMENTS; j++) begin
            if (IDX_W'(j) < lvl_r) begin
              cvalid_nxt[j] = cvalid_r[j];
            end else begin
              cvalid_nxt[j] = (IDX_W'(j) == lvl_r);
            end
          end
          wvalid_nxt = '0;
          k_nxt      = '0;
          state_nxt  = S_E0;
        end else if (lvl_r == '0) begin
          done_nxt  = 1'b1;
          state_nxt = S_EXH;
        end else begin
          lvl_nxt = lvl_r - IDX_W'(1);
          cre     = 1'b1;
          craddr  = lvl_r - IDX_W'(1);
        end
      end
      S_E0: begin
        cre       = 1'b1;
        craddr    = k_r;
        dre       = 1'b1;
        draddr    = {wvalid_r[k_r], k_r};
        state_nxt = S_E1;
      end
      S_E1: begin
        c_nxt     = emit_c;
        workk_nxt = drdata;
        dre       = 1'b1;
        draddr    = {wvalid_r[emit_c], emit_c};
        state_nxt = S_E2;
      end
      S_E2: begin
        if (out_free) begin
          emit.valid     = 1'b1;
          emit.value     = drdata;
          emit.position  = POS_W'(k_r);
          emit.last      = last_k;
          dwe            = 1'b1;
          dwaddr         = {1'b1, c_r};
          dwdata         = workk_r;
          wvalid_nxt[c_r] = 1'b1;
          if (last_k) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_E0;
          end
        end
      end
      S_EXH: begin
        if (out_free) begin
          emit.valid     = 1'b1;
          emit.exhausted = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      started_r <= 1'b0;
      done_r    <= 1'b0;
      cvalid_r  <= '0;
      wvalid_r  <= '0;
      lvl_r     <= '0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
      done_r    <= done_nxt;
      cvalid_r  <= cvalid_nxt;
      wvalid_r  <= wvalid_nxt;
      lvl_r     <= lvl_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r     <= c_nxt;
    workk_r <= workk_nxt;
  end

endmodule

@@ rtl/swap_permutation_enumerator_core.sv @@
// top level: count register, input handshake, result register and checks
// each transaction: an accept, plus for an advance the walk and the emission
// walk: steps down the choice stack from level n-2, none for the first permutation
// a walk that runs out at level 0 sets done, then the exhausted answer is given
// emission: E0, E1, E2 per position (one read port on the data ram); out_stall holds E2
// reset: synchronous active low, clears control state and sets the count to 8; ram undefined
`include "swap_permutation_enumerator_core_macros.svh"

module swap_permutation_enumerator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_opcode,
  input  logic [spe_pkg::POS_W-1:0]          in_position,
  input  logic signed [spe_pkg::VALUE_W-1:0] in_element_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [spe_pkg::VALUE_W-1:0] out_value,
  output logic [spe_pkg::POS_W-1:0]          out_position,
  output logic                               out_last_of_permutation,
  output logic                               out_exhausted,
  input  logic                               cfg_we,
  input  logic [spe_pkg::COUNT_W-1:0]        cfg_wdata
);
  import spe_pkg::*;

  logic [COUNT_W-1:0]        count_r;
  logic [N_W-1:0]            n_act;
  logic                      busy;
  logic                      in_fire;
  logic                      out_free;
  emit_t                     emit;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [POS_W-1:0]          out_position_r;
  logic                      out_last_r;
  logic                      out_exhausted_r;

  always_comb begin
    if (count_r == '0) begin
      n_act = N_W'(1);
    end else if (int'(count_r) > MAX_ELEMENTS) begin
      n_act = N_W'(MAX_ELEMENTS);
    end else begin
      n_act = N_W'(count_r);
    end
  end

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign out_free = !out_valid_r || !out_stall;

  spe_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_opcode        (in_opcode),
    .in_position      (in_position),
    .in_element_value (in_element_value),
    .cfg_we           (cfg_we),
    .n                (n_act),
    .out_free         (out_free),
    .busy             (busy),
    .emit             (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
      if (emit.valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_value_r     <= emit.value;
      out_position_r  <= emit.position;
      out_last_r      <= emit.last;
      out_exhausted_r <= emit.exhausted;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_value               = out_value_r;
  assign out_position            = out_position_r;
  assign out_last_of_permutation = out_last_r;
  assign out_exhausted           = out_exhausted_r;

  `SPE_ASSERT_NEXT(a_load_stays_idle, clk, rst_n,
                   in_fire && (in_opcode == OP_LOAD), !in_stall,
                   "load transaction left the block busy")
  `SPE_ASSERT_SAME(a_exhausted_clean, clk, rst_n, out_valid && out_exhausted,
                   !out_last_of_permutation && (out_value == '0) && (out_position == '0),
                   "exhausted result carries data")
  `SPE_ASSERT_SAME(a_position_in_range, clk, rst_n, out_valid && !out_exhausted,
                   N_W'(out_position) < n_act, "result position beyond element count")

endmodule
